[rtl/core/pli_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants for the piecewise linear interpolator.
// No dependencies; used by every module in rtl/core.
package pli_pkg;

  localparam int unsigned MaxPoints = 64;
  localparam int unsigned CntW      = 7;
  localparam int unsigned StepW     = 6;
  localparam int unsigned FracBits  = 16;
  localparam int unsigned DivSteps  = 49;
  localparam int unsigned MulSteps  = 33;

  localparam logic [CntW-1:0] CNT_RESET = 7'd2;
  localparam logic [CntW-1:0] CNT_MIN   = 7'd2;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_EVAL  = 1'b1;

  localparam logic signed [31:0] SAT_MAX = 32'sh7fff_ffff;
  localparam logic signed [31:0] SAT_MIN = 32'sh8000_0000;

  typedef struct packed {
    logic               op;
    logic [5:0]         point_index;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] query_x;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] result_y;
    logic               out_of_range;
  } out_item_t;

  typedef struct packed {
    logic wr;
    logic load_query;
    logic idx_last;
    logic idx_zero;
    logic idx_inc;
    logic lo_load;
    logic hi_load;
    logic set_oor;
    logic set_match;
    logic slope_zero;
    logic div_load;
    logic div_step;
    logic slope_set;
    logic mul_load;
    logic mul_step;
    logic scale;
    logic sum;
  } ctrl_cmd_t;

  typedef struct packed {
    logic above_last;
    logic x_eq;
    logic x_gt;
    logic dx_zero;
    logic cnt_last;
  } ctrl_sts_t;

endpackage

[rtl/core/pli_ctrl.sv]
`timescale 1ns / 1ps
// Sequencer for the interpolator: handshakes, segment walk, divide and multiply phases.
// Depends on pli_pkg.
module pli_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  logic                  in_op_i,
  output logic                  in_ready_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  input  pli_pkg::ctrl_sts_t    sts_i,
  output pli_pkg::ctrl_cmd_t    cmd_o
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_LAST  = 4'd1;
  localparam logic [3:0] S_FIRST = 4'd2;
  localparam logic [3:0] S_WALK  = 4'd3;
  localparam logic [3:0] S_PREP  = 4'd4;
  localparam logic [3:0] S_DIV   = 4'd5;
  localparam logic [3:0] S_SLOPE = 4'd6;
  localparam logic [3:0] S_MSET  = 4'd7;
  localparam logic [3:0] S_MUL   = 4'd8;
  localparam logic [3:0] S_SCALE = 4'd9;
  localparam logic [3:0] S_SUM   = 4'd10;
  localparam logic [3:0] S_OUT   = 4'd11;

  logic [3:0] state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = (state_q == S_OUT);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          if (in_op_i == pli_pkg::OP_EVAL) begin
            cmd_o.load_query = 1'b1;
            cmd_o.idx_last   = 1'b1;
            state_d          = S_LAST;
          end else begin
            cmd_o.wr = 1'b1;
          end
        end
      end
      S_LAST: begin
        if (sts_i.above_last) begin
          cmd_o.set_oor = 1'b1;
          state_d       = S_OUT;
        end else begin
          cmd_o.idx_zero = 1'b1;
          state_d        = S_FIRST;
        end
      end
      S_FIRST: begin
        cmd_o.lo_load = 1'b1;
        cmd_o.idx_inc = 1'b1;
        state_d       = S_WALK;
      end
      S_WALK: begin
        if (sts_i.x_eq) begin
          cmd_o.set_match = 1'b1;
          state_d         = S_OUT;
        end else if (sts_i.x_gt) begin
          cmd_o.hi_load = 1'b1;
          state_d       = S_PREP;
        end else begin
          cmd_o.lo_load = 1'b1;
          cmd_o.idx_inc = 1'b1;
        end
      end
      S_PREP: begin
        if (sts_i.dx_zero) begin
          cmd_o.slope_zero = 1'b1;
          state_d          = S_MSET;
        end else begin
          cmd_o.div_load = 1'b1;
          state_d        = S_DIV;
        end
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.cnt_last) begin
          state_d = S_SLOPE;
        end
      end
      S_SLOPE: begin
        cmd_o.slope_set = 1'b1;
        state_d         = S_MSET;
      end
      S_MSET: begin
        cmd_o.mul_load = 1'b1;
        state_d        = S_MUL;
      end
      S_MUL: begin
        cmd_o.mul_step = 1'b1;
        if (sts_i.cnt_last) begin
          state_d = S_SCALE;
        end
      end
      S_SCALE: begin
        cmd_o.scale = 1'b1;
        state_d     = S_SUM;
      end
      S_SUM: begin
        cmd_o.sum = 1'b1;
        state_d   = S_OUT;
      end
      S_OUT: begin
        if (out_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

[rtl/core/pli_dpath.sv]
`timescale 1ns / 1ps
// Datapath: breakpoint memory, segment registers, serial divider, serial multiplier.
// Depends on pli_pkg; driven by pli_ctrl commands.
module pli_dpath (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  pli_pkg::in_item_t             in_data_i,
  input  logic [pli_pkg::CntW-1:0]      count_i,
  input  pli_pkg::ctrl_cmd_t            cmd_i,
  output pli_pkg::ctrl_sts_t            sts_o,
  output pli_pkg::out_item_t            out_data_o
);

  localparam int unsigned AW = $clog2(pli_pkg::MaxPoints);

  logic [63:0]          mem [pli_pkg::MaxPoints];
  logic [63:0]          rdata_q;
  logic [AW-1:0]        idx_q, idx_d;
  logic [pli_pkg::CntW-1:0] n_m1;

  logic signed [31:0]   qx_q, x1_q, y1_q, x2_q, y2_q, m_q;
  logic signed [31:0]   rd_x, rd_y;
  logic [32:0]          den_q;
  logic [33:0]          rem_q;
  logic [48:0]          quo_q;
  logic                 dsign_q, psign_q;
  logic [65:0]          prod_q;
  logic [31:0]          mcand_q;
  logic signed [50:0]   t_q;
  logic [pli_pkg::StepW-1:0] cnt_q;
  pli_pkg::out_item_t   res_q;

  logic signed [32:0]   dx, dy, xd;
  logic [32:0]          dx_mag, dy_mag, xd_mag;
  logic [33:0]          rem_sh;
  logic [34:0]          diff;
  logic                 ge;
  logic [31:0]          m_mag;
  logic [33:0]          madd;
  logic [49:0]          pmag;
  logic signed [50:0]   ysum;
  logic                 wr_ok;

  assign rd_x = rdata_q[63:32];
  assign rd_y = rdata_q[31:0];
  assign n_m1 = count_i - pli_pkg::CntW'(1);

  always_comb begin
    if (cmd_i.idx_last) begin
      idx_d = AW'(n_m1);
    end else if (cmd_i.idx_zero) begin
      idx_d = '0;
    end else if (cmd_i.idx_inc) begin
      idx_d = idx_q + AW'(1);
    end else begin
      idx_d = idx_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
      cnt_q <= '0;
    end else begin
      idx_q <= idx_d;
      if (cmd_i.div_load) begin
        cnt_q <= pli_pkg::StepW'(pli_pkg::DivSteps);
      end else if (cmd_i.mul_load) begin
        cnt_q <= pli_pkg::StepW'(pli_pkg::MulSteps);
      end else if (cmd_i.div_step || cmd_i.mul_step) begin
        cnt_q <= cnt_q - pli_pkg::StepW'(1);
      end
    end
  end

  assign wr_ok = (32'(in_data_i.point_index) < 32'(pli_pkg::MaxPoints));

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr && wr_ok) begin
      mem[AW'(in_data_i.point_index)] <= {in_data_i.point_x, in_data_i.point_y};
    end
    rdata_q <= mem[idx_d];
  end

  // segment deltas
  assign dx     = {x2_q[31], x2_q} - {x1_q[31], x1_q};
  assign dy     = {y2_q[31], y2_q} - {y1_q[31], y1_q};
  assign xd     = {qx_q[31], qx_q} - {x1_q[31], x1_q};
  assign dx_mag = dx[32] ? 33'(-dx) : 33'(dx);
  assign dy_mag = dy[32] ? 33'(-dy) : 33'(dy);
  assign xd_mag = xd[32] ? 33'(-xd) : 33'(xd);

  // restoring divide, one quotient bit per cycle
  assign rem_sh = {rem_q[32:0], quo_q[48]};
  assign diff   = {1'b0, rem_sh} - {2'b00, den_q};
  assign ge     = ~diff[34];

  assign m_mag  = m_q[31] ? 32'(-m_q) : 32'(m_q);
  assign madd   = {1'b0, prod_q[65:33]} + {2'b00, (prod_q[0] ? mcand_q : 32'd0)};
  assign pmag   = prod_q[65:pli_pkg::FracBits];
  assign ysum   = {{19{y1_q[31]}}, y1_q} + t_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_query) begin
      qx_q <= in_data_i.query_x;
    end
    if (cmd_i.lo_load) begin
      x1_q <= rd_x;
      y1_q <= rd_y;
    end
    if (cmd_i.hi_load) begin
      x2_q <= rd_x;
      y2_q <= rd_y;
    end
    if (cmd_i.div_load) begin
      quo_q   <= {dy_mag[32:0], {pli_pkg::FracBits{1'b0}}};
      rem_q   <= '0;
      den_q   <= dx_mag;
      dsign_q <= dx[32] ^ dy[32];
    end else if (cmd_i.div_step) begin
      quo_q <= {quo_q[47:0], ge};
      rem_q <= ge ? diff[33:0] : rem_sh;
    end
    if (cmd_i.slope_zero) begin
      m_q <= '0;
    end else if (cmd_i.slope_set) begin
      if (dsign_q) begin
        m_q <= (quo_q > 49'h0_8000_0000) ? pli_pkg::SAT_MIN : 32'(49'd0 - quo_q);
      end else begin
        m_q <= (quo_q > 49'h0_7fff_ffff) ? pli_pkg::SAT_MAX : 32'(quo_q);
      end
    end
    if (cmd_i.mul_load) begin
      prod_q  <= {33'd0, xd_mag};
      mcand_q <= m_mag;
      psign_q <= m_q[31] ^ xd[32];
    end else if (cmd_i.mul_step) begin
      prod_q <= {madd, prod_q[32:1]};
    end
    if (cmd_i.scale) begin
      t_q <= psign_q ? 51'(-{1'b0, pmag}) : 51'({1'b0, pmag});
    end
    if (cmd_i.set_oor) begin
      res_q.result_y     <= '0;
      res_q.out_of_range <= 1'b1;
    end else if (cmd_i.set_match) begin
      res_q.result_y     <= rd_y;
      res_q.out_of_range <= 1'b0;
    end else if (cmd_i.sum) begin
      if (ysum > 51'sd2147483647) begin
        res_q.result_y <= pli_pkg::SAT_MAX;
      end else if (ysum < -51'sd2147483648) begin
        res_q.result_y <= pli_pkg::SAT_MIN;
      end else begin
        res_q.result_y <= ysum[31:0];
      end
      res_q.out_of_range <= 1'b0;
    end
  end

  assign sts_o.above_last = (qx_q > rd_x);
  assign sts_o.x_eq       = (rd_x == qx_q);
  assign sts_o.x_gt       = (rd_x > qx_q);
  assign sts_o.dx_zero    = (dx == 33'sd0);
  assign sts_o.cnt_last   = (cnt_q == pli_pkg::StepW'(1));

  assign out_data_o = res_q;

endmodule

[rtl/core/piecewise_linear_interpolator.sv]
`timescale 1ns / 1ps
// Piecewise linear interpolator, Q16.16. Write beats are stored while idle. Evaluate beat: an
// out-of-range query is flagged after the last breakpoint is checked; otherwise the segment
// walk runs and ends at an exact match or goes on to the serial divide and serial multiply
// (divide skipped for equal x). One beat in flight; input is taken again once the result leaves.
// Async active-low reset: point_count = 2, sequencer idle; breakpoint memory not cleared.
// Depends on pli_pkg, pli_ctrl, pli_dpath.
module piecewise_linear_interpolator (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  pli_pkg::in_item_t            in_data_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output pli_pkg::out_item_t           out_data_o,
  input  logic                         cfg_we_i,
  input  logic [pli_pkg::CntW-1:0]     cfg_wdata_i
);

  logic [pli_pkg::CntW-1:0] count_q, count_d;
  pli_pkg::ctrl_cmd_t       cmd;
  pli_pkg::ctrl_sts_t       sts;

  always_comb begin
    count_d = count_q;
    if (cfg_we_i && (cfg_wdata_i >= pli_pkg::CNT_MIN)) begin
      if (32'(cfg_wdata_i) > 32'(pli_pkg::MaxPoints)) begin
        count_d = pli_pkg::CntW'(pli_pkg::MaxPoints);
      end else begin
        count_d = cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= pli_pkg::CNT_RESET;
    end else begin
      count_q <= count_d;
    end
  end

  pli_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_op_i     (in_data_i.op),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  pli_dpath u_dpath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_data_i  (in_data_i),
    .count_i    (count_q),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .out_data_o (out_data_o)
  );

endmodule

[tb/tb.sv]
`timescale 1ns / 1ps
// Self-checking testbench for piecewise_linear_interpolator: random and directed breakpoint
// tables and queries, each result predicted in-bench and compared field by field.
// Depends on pli_pkg and the interpolator RTL.
module tb;
  import pli_pkg::*;

  localparam int WatchdogLimit = 4000;
  localparam int DrainCycles   = 8;
  localparam int TailCycles    = 200;
  localparam longint MinQ      = SAT_MIN;
  localparam longint MaxQ      = SAT_MAX;

  typedef enum int {TBL_SORTED, TBL_STEEP, TBL_UNSORTED} table_kind_e;

  typedef struct {
    out_item_t          res;
    logic signed [31:0] query;
  } expected_t;

  logic            clk_i;
  logic            rst_ni      = 1'b0;
  logic            in_valid_i  = 1'b0;
  logic            in_ready_o;
  in_item_t        in_data_i   = '0;
  logic            out_valid_o;
  logic            out_ready_i = 1'b0;
  out_item_t       out_data_o;
  logic            cfg_we_i    = 1'b0;
  logic [CntW-1:0] cfg_wdata_i = '0;

  piecewise_linear_interpolator dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  // predicted block state
  logic signed [31:0] bp_x [MaxPoints];
  logic signed [31:0] bp_y [MaxPoints];
  int                 active_points = CNT_RESET;
  expected_t          pending_results[$];
  expected_t          oldest;

  int send_gap_pct    = 0;
  int recv_stall_pct  = 0;
  int beats_sent      = 0;
  int writes_sent     = 0;
  int evals_sent      = 0;
  int results_checked = 0;
  int oor_seen        = 0;
  int mismatches      = 0;
  int quiet_cycles    = 0;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  function automatic longint clamp32(input longint v);
    if (v > MaxQ) return MaxQ;
    if (v < MinQ) return MinQ;
    return v;
  endfunction

  function automatic longint rand_between(input longint lo, input longint hi);
    longint unsigned span;
    longint unsigned r;
    if (hi <= lo) return lo;
    span = hi - lo;
    span = span + 1;
    r = {$urandom, $urandom};
    return lo + (r % span);
  endfunction

  function automatic longint segment_y(input longint x1, input longint y1, input longint x2,
                                       input longint y2, input longint q);
    longint dx;
    longint slope;
    dx = x2 - x1;
    slope = 0;
    if (dx != 0) slope = clamp32(((y2 - y1) * 65536) / dx);
    return clamp32(y1 + (slope * (q - x1)) / 65536);
  endfunction

  function automatic out_item_t interpolate_at(input logic signed [31:0] q);
    out_item_t res;
    longint    x1;
    longint    y1;
    longint    yv;
    bit        done;
    res = '0;
    if (q > bp_x[active_points-1]) begin
      res.out_of_range = 1'b1;
      return res;
    end
    x1 = bp_x[0];
    y1 = bp_y[0];
    yv = 0;
    done = 1'b0;
    for (int i = 1; i < active_points && !done; i++) begin
      if (bp_x[i] == q) begin
        yv = bp_y[i];
        done = 1'b1;
      end else if (bp_x[i] > q) begin
        yv = segment_y(x1, y1, bp_x[i], bp_y[i], q);
        done = 1'b1;
      end else begin
        x1 = bp_x[i];
        y1 = bp_y[i];
      end
    end
    res.result_y = yv[31:0];
    return res;
  endfunction

  task automatic report_mismatch(input string what);
    $display("MISMATCH @%0t: %s", $time, what);
    mismatches++;
  endtask

  // called at a falling edge; returns at the falling edge after the beat is taken
  task automatic send_beat(input in_item_t beat);
    expected_t e;
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= beat;
    do @(posedge clk_i); while (!in_ready_o);
    beats_sent++;
    if (beat.op == OP_WRITE) begin
      bp_x[beat.point_index] = beat.point_x;
      bp_y[beat.point_index] = beat.point_y;
      writes_sent++;
    end else begin
      e.res   = interpolate_at(beat.query_x);
      e.query = beat.query_x;
      pending_results.push_back(e);
      evals_sent++;
    end
    @(negedge clk_i);
  endtask

  task automatic write_point(input int idx, input longint x, input longint y);
    in_item_t beat;
    beat.op          = OP_WRITE;
    beat.point_index = idx[5:0];
    beat.point_x     = x[31:0];
    beat.point_y     = y[31:0];
    beat.query_x     = $urandom;
    send_beat(beat);
  endtask

  task automatic evaluate(input longint q);
    in_item_t beat;
    beat.op          = OP_EVAL;
    beat.point_index = 6'($urandom);
    beat.point_x     = $urandom;
    beat.point_y     = $urandom;
    beat.query_x     = q[31:0];
    send_beat(beat);
  endtask

  // register writes only with nothing in flight
  task automatic set_point_count(input logic [CntW-1:0] value);
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    if (value >= CNT_MIN) active_points = (value > MaxPoints) ? MaxPoints : value;
  endtask

  function automatic longint random_y(input int mode);
    longint v;
    case (mode)
      0: v = rand_between(MinQ, MaxQ);
      1: v = rand_between(-1048576, 1048576);
      default: begin
        case ($urandom_range(3))
          0: v = MinQ;
          1: v = MaxQ;
          2: v = 0;
          default: v = -1;
        endcase
      end
    endcase
    return v;
  endfunction

  function automatic longint pick_query(input int n);
    int     i;
    longint a;
    longint b;
    longint q;
    i = $urandom_range(n - 1);
    case ($urandom_range(9))
      0, 1: q = bp_x[i];
      2: q = clamp32(bp_x[i] + rand_between(-2, 2));
      3, 4, 5: begin
        if (i == 0) i = 1;
        a = bp_x[i-1];
        b = bp_x[i];
        q = (a < b) ? rand_between(a, b) : rand_between(b, a);
      end
      6: q = rand_between(MinQ, bp_x[0]);
      7: q = rand_between(bp_x[n-1], MaxQ);
      8: q = rand_between(MinQ, MaxQ);
      default: q = bp_x[n-1];
    endcase
    return q;
  endfunction

  task automatic load_table(input int n, input table_kind_e kind);
    longint step_max;
    longint x;
    int     ymode;
    if (kind == TBL_UNSORTED) begin
      ymode = $urandom_range(2);
      for (int i = 0; i < n; i++) begin
        x = $urandom_range(1) ? rand_between(-64, 64) : rand_between(MinQ, MaxQ);
        write_point(i, x, random_y(ymode));
      end
    end else begin
      if (kind == TBL_STEEP) begin
        step_max = $urandom_range(1, 3);
        ymode = $urandom_range(1) ? 2 : 0;
      end else begin
        step_max = 1;
        step_max = step_max << $urandom_range(26);
        ymode = $urandom_range(2);
      end
      if (step_max > (MaxQ - MinQ) / (n - 1)) step_max = (MaxQ - MinQ) / (n - 1);
      x = rand_between(MinQ, MaxQ - (n - 1) * step_max);
      for (int i = 0; i < n; i++) begin
        write_point(i, x, random_y(ymode));
        x += rand_between(0, step_max);
      end
    end
  endtask

  // set a count, fill that many points, query, with the odd stray overwrite
  task automatic run_table_sessions(input table_kind_e kind, input int target);
    int stop_at;
    int n;
    int r;
    stop_at = beats_sent + target;
    while (beats_sent < stop_at) begin
      r = $urandom_range(99);
      if (r < 70) n = $urandom_range(2, 8);
      else if (r < 95) n = $urandom_range(9, 24);
      else n = $urandom_range(25, MaxPoints);
      set_point_count(n[CntW-1:0]);
      load_table(n, kind);
      repeat ($urandom_range(4, 12)) begin
        if ($urandom_range(19) == 0)
          write_point($urandom_range(MaxPoints - 1), rand_between(MinQ, MaxQ),
                      rand_between(MinQ, MaxQ));
        evaluate(pick_query(n));
      end
    end
  endtask

  // runs on the reset count of two
  task automatic test_two_point_cases();
    write_point(0, 0, 0);
    write_point(1, 65536, 10 * 65536);
    evaluate(32768);
    evaluate(0);
    evaluate(65536);
    evaluate(65537);
    evaluate(-65536);
    evaluate(MinQ);
    // equal x, zero slope
    write_point(0, 100, 5);
    write_point(1, 100, 9);
    evaluate(100);
    evaluate(50);
    evaluate(101);
    write_point(0, MinQ, MaxQ);
    write_point(1, MaxQ, MinQ);
    evaluate(0);
    evaluate(MaxQ);
    evaluate(MinQ);
    // slope and result saturation
    write_point(0, 0, MinQ);
    write_point(1, 1, MaxQ);
    evaluate(0);
    evaluate(-6553600);
    write_point(0, 0, MaxQ);
    write_point(1, 1, MinQ);
    evaluate(-100000);
    evaluate(1);
  endtask

  task automatic test_sorted_tables(input int target);
    run_table_sessions(TBL_SORTED, target);
  endtask

  task automatic test_unsorted_tables(input int target);
    run_table_sessions(TBL_UNSORTED, target);
  endtask

  task automatic test_steep_segments(input int target);
    run_table_sessions(TBL_STEEP, target);
  endtask

  // refused, clipped and legal counts over a full table
  task automatic test_point_count_register();
    logic [CntW-1:0] steps [8];
    steps = '{7'd0, 7'd1, 7'd127, 7'd3, 7'd65, 7'd2, 7'd64, 7'd5};
    set_point_count(7'd64);
    load_table(MaxPoints, TBL_SORTED);
    foreach (steps[s]) begin
      set_point_count(steps[s]);
      repeat (4) evaluate(pick_query(active_points));
    end
  endtask

  always @(negedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("result beat with nothing pending: y=%0d flag=%0b",
                                  out_data_o.result_y, out_data_o.out_of_range));
      end else begin
        oldest = pending_results.pop_front();
        results_checked++;
        if (oldest.res.out_of_range) oor_seen++;
        if (out_data_o.result_y !== oldest.res.result_y)
          report_mismatch($sformatf("x=%0d result_y got %0d want %0d", oldest.query,
                                    out_data_o.result_y, oldest.res.result_y));
        if (out_data_o.out_of_range !== oldest.res.out_of_range)
          report_mismatch($sformatf("x=%0d out_of_range got %0b want %0b", oldest.query,
                                    out_data_o.out_of_range, oldest.res.out_of_range));
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || cfg_we_i) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WatchdogLimit) begin
      $display("watchdog: %0d cycles without a beat, %0d results pending",
               quiet_cycles, pending_results.size());
      $display("FAILED: results differ");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    send_gap_pct   = 13;
    recv_stall_pct = 68;
    test_two_point_cases();
    test_sorted_tables(500);
    test_point_count_register();

    send_gap_pct   = 68;
    recv_stall_pct = 13;
    test_sorted_tables(400);
    test_unsorted_tables(200);

    send_gap_pct   = 0;
    recv_stall_pct = 0;
    test_steep_segments(200);
    test_sorted_tables(400);

    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk_i);
    repeat (TailCycles) @(negedge clk_i);

    $display("Covered %0d beats: %0d breakpoint writes, %0d evaluations, counts 2..64.",
             beats_sent, writes_sent, evals_sent);
    $display("Compared %0d results (%0d out of range), %0d mismatches.",
             results_checked, oor_seen, mismatches);
    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
